[rtl/twc_pkg.sv]
// Package for the thresholded weighted centroid block: constants, beat types and state codes.
package twc_pkg;

    localparam int CHANNELS    = 60;
    localparam int CH_BITS     = $clog2(CHANNELS);
    localparam int SAMPLE_BITS = 16;
    localparam int COORD_BITS  = 8;
    localparam int WSUM_BITS   = 30;
    localparam int ASUM_BITS   = 22;
    localparam int ACT_BITS    = SAMPLE_BITS;
    localparam int PROD_BITS   = ACT_BITS + COORD_BITS;
    localparam int OUT_BITS    = 16;
    localparam int FRAC_BITS   = 8;
    localparam int DIV_STEPS   = OUT_BITS;
    localparam int STEP_BITS   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic REQ_SETUP  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [5:0]               channel;
        logic signed [15:0]       sample_value;
        logic signed [15:0]       threshold_value;
        logic signed [15:0]       minimum_value;
        logic [7:0]               x_position;
        logic [7:0]               y_position;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic        has_center;
        logic [15:0] center_x;
        logic [15:0] center_y;
    } result_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] threshold;
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic [COORD_BITS-1:0]         x_pos;
        logic [COORD_BITS-1:0]         y_pos;
    } chan_entry_t;

    typedef struct packed {
        logic                 spike;
        logic [WSUM_BITS-1:0] x_sum;
        logic [WSUM_BITS-1:0] y_sum;
        logic [ASUM_BITS-1:0] act_sum;
    } frame_sums_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_DONE
    } back_state_t;

endpackage

[rtl/thresholded_weighted_centroid.sv]
// Top level of the thresholded weighted centroid block.
// The item channel (item_valid, item_stall, item) carries one beat per setup load or
// frame sample. Setup beats fill the per-channel threshold, minimum and grid position;
// a setup beat marked last arms the block, and samples before that are dropped.
// The result channel (result_valid, result_stall, result) gives one beat per armed frame,
// on the frame's last sample: the spike flag and the centroid x and y in Q8.8.
// Samples are taken one per cycle while item_stall is low. Three pipeline stages (table
// read, multiply, accumulate) feed a two-entry queue of finished frame sums. The divider
// then works one quotient bit per cycle for both coordinates. While the result beat is
// stalled it holds, and samples keep flowing until the queue holds two finished frames
// and a further frame's last sample reaches the accumulate stage; only then does
// item_stall rise.
// After reset the block is unarmed, the frame sums are zero and the channel tables hold
// nothing defined until setup beats write them.
module thresholded_weighted_centroid
    import twc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic        push;
    frame_sums_t push_data;
    logic        queue_full;
    logic        q_valid;
    logic        pop;
    frame_sums_t q_data;

    twc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    twc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_data    (q_data)
    );

    twc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[rtl/twc_front.sv]
// Front end: accepts beats, keeps the channel tables and accumulates the frame sums.
module twc_front
    import twc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        push,
    output frame_sums_t push_data,
    input  logic        queue_full
);

    chan_entry_t chan_mem [CHANNELS];
    chan_entry_t rd_word_reg;

    logic  s1_valid_reg;
    item_t s1_item_reg;

    logic               fwd_valid_reg;
    logic [CH_BITS-1:0] fwd_ch_reg;
    chan_entry_t        fwd_word_reg;

    logic armed_reg;

    logic                  s2_valid_reg;
    logic                  s2_add_reg;
    logic                  s2_close_reg;
    logic [ACT_BITS-1:0]   s2_act_reg;
    logic [COORD_BITS-1:0] s2_x_reg;
    logic [COORD_BITS-1:0] s2_y_reg;

    logic                 s3_valid_reg;
    logic                 s3_add_reg;
    logic                 s3_close_reg;
    logic [ACT_BITS-1:0]  s3_act_reg;
    logic [PROD_BITS-1:0] s3_px_reg;
    logic [PROD_BITS-1:0] s3_py_reg;

    logic                 spike_reg;
    logic [WSUM_BITS-1:0] x_sum_reg;
    logic [WSUM_BITS-1:0] y_sum_reg;
    logic [ASUM_BITS-1:0] act_sum_reg;

    logic hold;
    logic advance;
    logic accept;

    logic                          s1_in_range;
    logic [CH_BITS-1:0]            s1_idx;
    logic                          s1_is_sample;
    chan_entry_t                   cur_word;
    logic signed [SAMPLE_BITS-1:0] new_min;
    logic                          s1_spike;
    logic [SAMPLE_BITS:0]          diff;
    logic                          wr_en;
    chan_entry_t                   wr_word;
    logic                          s1_add;
    logic                          s1_close;

    logic [WSUM_BITS:0]   x_wide;
    logic [WSUM_BITS:0]   y_wide;
    logic [ASUM_BITS:0]   a_wide;
    logic [WSUM_BITS-1:0] x_acc;
    logic [WSUM_BITS-1:0] y_acc;
    logic [ASUM_BITS-1:0] a_acc;
    logic                 spike_acc;

    assign hold       = s3_valid_reg && s3_close_reg && queue_full;
    assign advance    = !hold;
    assign item_stall = hold;
    assign accept     = item_valid && advance;

    // A write from the previous beat is not yet visible in the registered read.
    always_comb
    begin
        s1_in_range  = (32'(s1_item_reg.channel) < CHANNELS);
        s1_idx       = s1_item_reg.channel[CH_BITS-1:0];
        s1_is_sample = (s1_item_reg.req_type == REQ_SAMPLE);
        cur_word     = (fwd_valid_reg && (fwd_ch_reg == s1_idx)) ? fwd_word_reg : rd_word_reg;
        new_min      = (s1_item_reg.sample_value < cur_word.minimum) ?
                       s1_item_reg.sample_value : cur_word.minimum;
        s1_spike     = (s1_item_reg.sample_value > cur_word.threshold);
        diff         = {s1_item_reg.sample_value[SAMPLE_BITS-1], s1_item_reg.sample_value}
                       - {new_min[SAMPLE_BITS-1], new_min};
        wr_en        = s1_valid_reg && s1_in_range && (!s1_is_sample || armed_reg);
        if (s1_is_sample)
        begin
            wr_word = '{threshold: cur_word.threshold, minimum: new_min,
                        x_pos: cur_word.x_pos, y_pos: cur_word.y_pos};
        end
        else
        begin
            wr_word = '{threshold: s1_item_reg.threshold_value,
                        minimum: s1_item_reg.minimum_value,
                        x_pos: s1_item_reg.x_position[COORD_BITS-1:0],
                        y_pos: s1_item_reg.y_position[COORD_BITS-1:0]};
        end
        s1_add   = s1_valid_reg && s1_is_sample && armed_reg && s1_in_range && s1_spike;
        s1_close = s1_valid_reg && s1_is_sample && armed_reg && s1_item_reg.last;
    end

    always_comb
    begin
        x_wide    = {1'b0, x_sum_reg} + (WSUM_BITS+1)'(s3_px_reg);
        y_wide    = {1'b0, y_sum_reg} + (WSUM_BITS+1)'(s3_py_reg);
        a_wide    = {1'b0, act_sum_reg} + (ASUM_BITS+1)'(s3_act_reg);
        x_acc     = x_sum_reg;
        y_acc     = y_sum_reg;
        a_acc     = act_sum_reg;
        spike_acc = spike_reg;
        if (s3_add_reg)
        begin
            x_acc     = x_wide[WSUM_BITS] ? '1 : x_wide[WSUM_BITS-1:0];
            y_acc     = y_wide[WSUM_BITS] ? '1 : y_wide[WSUM_BITS-1:0];
            a_acc     = a_wide[ASUM_BITS] ? '1 : a_wide[ASUM_BITS-1:0];
            spike_acc = 1'b1;
        end
        push      = advance && s3_valid_reg && s3_close_reg;
        push_data = '{spike: spike_acc, x_sum: x_acc, y_sum: y_acc, act_sum: a_acc};
    end

    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            chan_mem[s1_idx] <= wr_word;
        end
        if (accept)
        begin
            rd_word_reg <= chan_mem[item.channel[CH_BITS-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            armed_reg     <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_add_reg    <= 1'b0;
            s2_close_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s3_add_reg    <= 1'b0;
            s3_close_reg  <= 1'b0;
            spike_reg     <= 1'b0;
            x_sum_reg     <= '0;
            y_sum_reg     <= '0;
            act_sum_reg   <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= item_valid;
            fwd_valid_reg <= wr_en;
            if (s1_valid_reg && !s1_is_sample && s1_item_reg.last)
            begin
                armed_reg <= 1'b1;
            end
            s2_valid_reg <= s1_valid_reg;
            s2_add_reg   <= s1_add;
            s2_close_reg <= s1_close;
            s3_valid_reg <= s2_valid_reg;
            s3_add_reg   <= s2_valid_reg && s2_add_reg;
            s3_close_reg <= s2_valid_reg && s2_close_reg;
            if (s3_valid_reg)
            begin
                if (s3_close_reg)
                begin
                    spike_reg   <= 1'b0;
                    x_sum_reg   <= '0;
                    y_sum_reg   <= '0;
                    act_sum_reg <= '0;
                end
                else
                begin
                    spike_reg   <= spike_acc;
                    x_sum_reg   <= x_acc;
                    y_sum_reg   <= y_acc;
                    act_sum_reg <= a_acc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            fwd_ch_reg   <= s1_idx;
            fwd_word_reg <= wr_word;
            s2_act_reg   <= diff[ACT_BITS-1:0];
            s2_x_reg     <= cur_word.x_pos;
            s2_y_reg     <= cur_word.y_pos;
            s3_act_reg   <= s2_act_reg;
            s3_px_reg    <= PROD_BITS'(s2_act_reg) * PROD_BITS'(s2_x_reg);
            s3_py_reg    <= PROD_BITS'(s2_act_reg) * PROD_BITS'(s2_y_reg);
        end
    end

endmodule

[rtl/twc_queue.sv]
// Short queue of finished frame sums between the front end and the divider.
module twc_queue
    import twc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_sums_t push_data,
    output logic        full,
    output logic        q_valid,
    input  logic        pop,
    output frame_sums_t q_data
);

    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    frame_sums_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/twc_back.sv]
// Back end: divides the frame sums one quotient bit a cycle and holds the result beat.
module twc_back
    import twc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  frame_sums_t q_data,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [ASUM_BITS-1:0] rx_reg;
    logic [ASUM_BITS-1:0] ry_reg;
    logic [OUT_BITS-1:0]  shx_reg;
    logic [OUT_BITS-1:0]  shy_reg;
    logic [OUT_BITS-1:0]  qx_reg;
    logic [OUT_BITS-1:0]  qy_reg;
    logic [ASUM_BITS-1:0] div_reg;
    logic                 satx_reg;
    logic                 saty_reg;
    logic                 zero_reg;
    logic                 spike_reg;
    logic [STEP_BITS-1:0] step_reg;
    result_t              result_reg;

    logic                 load;
    logic                 stepping;
    logic                 last_step;
    logic [ASUM_BITS:0]   tx;
    logic [ASUM_BITS:0]   ty;
    logic [ASUM_BITS:0]   dx;
    logic [ASUM_BITS:0]   dy;
    logic                 gex;
    logic                 gey;
    logic [ASUM_BITS-1:0] rx_next;
    logic [ASUM_BITS-1:0] ry_next;
    logic [OUT_BITS-1:0]  qx_next;
    logic [OUT_BITS-1:0]  qy_next;

    assign last_step = (step_reg == STEP_BITS'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (last_step)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!result_stall)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load         = (state_reg == BK_IDLE) && q_valid;
        pop          = load;
        stepping     = (state_reg == BK_DIVIDE);
        result_valid = (state_reg == BK_DONE);
        result       = result_reg;
    end

    always_comb
    begin
        tx      = {rx_reg, shx_reg[OUT_BITS-1]};
        ty      = {ry_reg, shy_reg[OUT_BITS-1]};
        dx      = tx - {1'b0, div_reg};
        dy      = ty - {1'b0, div_reg};
        gex     = (tx >= {1'b0, div_reg});
        gey     = (ty >= {1'b0, div_reg});
        rx_next = gex ? dx[ASUM_BITS-1:0] : tx[ASUM_BITS-1:0];
        ry_next = gey ? dy[ASUM_BITS-1:0] : ty[ASUM_BITS-1:0];
        qx_next = {qx_reg[OUT_BITS-2:0], gex};
        qy_next = {qy_reg[OUT_BITS-2:0], gey};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The quotient only fits in the output when the sum is below 256 times the activity.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rx_reg    <= q_data.x_sum[WSUM_BITS-1:FRAC_BITS];
            ry_reg    <= q_data.y_sum[WSUM_BITS-1:FRAC_BITS];
            shx_reg   <= {q_data.x_sum[FRAC_BITS-1:0], {(OUT_BITS-FRAC_BITS){1'b0}}};
            shy_reg   <= {q_data.y_sum[FRAC_BITS-1:0], {(OUT_BITS-FRAC_BITS){1'b0}}};
            div_reg   <= q_data.act_sum;
            satx_reg  <= (q_data.x_sum >= {q_data.act_sum, {FRAC_BITS{1'b0}}});
            saty_reg  <= (q_data.y_sum >= {q_data.act_sum, {FRAC_BITS{1'b0}}});
            zero_reg  <= (q_data.act_sum == '0);
            spike_reg <= q_data.spike;
            qx_reg    <= '0;
            qy_reg    <= '0;
            step_reg  <= '0;
        end
        else if (stepping)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            shx_reg  <= {shx_reg[OUT_BITS-2:0], 1'b0};
            shy_reg  <= {shy_reg[OUT_BITS-2:0], 1'b0};
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            step_reg <= step_reg + 1'b1;
            if (last_step)
            begin
                result_reg.has_center <= spike_reg;
                result_reg.center_x   <= zero_reg ? '0 : (satx_reg ? '1 : qx_next);
                result_reg.center_y   <= zero_reg ? '0 : (saty_reg ? '1 : qy_next);
            end
        end
    end

endmodule

[rtl/twc_checker.sv]
// Port checker for the thresholded weighted centroid block and its bind statement.
module twc_port_checks
    import twc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(item_stall))
        else $error("item_stall unknown out of reset");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed or dropped while stalled");

    a_no_center_x: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_center |-> result.center_x == '0)
        else $error("center_x nonzero in a frame without a spike");

    a_no_center_y: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_center |-> result.center_y == '0)
        else $error("center_y nonzero in a frame without a spike");

    a_one_result_per_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall |=> !result_valid)
        else $error("result beats issued back to back");

endmodule

bind thresholded_weighted_centroid twc_port_checks u_twc_port_checks (.*);

[test/twc_checker.sv]
// Checker for the thresholded weighted centroid block: predicts every frame result and compares.
`timescale 1ns / 1ps
module twc_checker
    import twc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      errors,
    output int      pending,
    output int      frames_checked,
    output int      frames_with_spike
);

    localparam longint unsigned WSUM_MAX   = (64'd1 << WSUM_BITS) - 1;
    localparam longint unsigned ASUM_MAX   = (64'd1 << ASUM_BITS) - 1;
    localparam longint unsigned CENTER_MAX = (64'd1 << OUT_BITS) - 1;

    logic signed [SAMPLE_BITS-1:0] thr_table [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] min_table [CHANNELS];
    logic [COORD_BITS-1:0]         x_table [CHANNELS];
    logic [COORD_BITS-1:0]         y_table [CHANNELS];
    logic                          armed;
    logic                          spike_seen;
    longint unsigned               x_sum;
    longint unsigned               y_sum;
    longint unsigned               act_sum;
    result_t                       centers_due [$];

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                                longint unsigned ceiling);
        longint unsigned s;
        s = a + b;
        return (s > ceiling) ? ceiling : s;
    endfunction

    function automatic logic [OUT_BITS-1:0] center_of(longint unsigned wsum,
                                                      longint unsigned act);
        longint unsigned q;
        if (act == 0)
            return '0;
        q = (wsum << FRAC_BITS) / act;
        if (q > CENTER_MAX)
            return '1;
        return q[OUT_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic fold_item(input item_t b);
        int              ch;
        int              s;
        int              act;
        longint unsigned act64;
        result_t         r;
        ch = int'(b.channel);
        if (b.req_type == REQ_SETUP)
        begin
            if (ch < CHANNELS)
            begin
                thr_table[ch] = b.threshold_value;
                min_table[ch] = b.minimum_value;
                x_table[ch]   = b.x_position;
                y_table[ch]   = b.y_position;
            end
            if (b.last)
                armed = 1'b1;
        end
        else if (armed)
        begin
            if (ch < CHANNELS)
            begin
                s = int'(b.sample_value);
                if (s < min_table[ch])
                    min_table[ch] = b.sample_value;
                if (s > thr_table[ch])
                begin
                    act = s - min_table[ch];
                    if (act < 0)
                        act = -act;
                    act64      = 64'(act);
                    spike_seen = 1'b1;
                    x_sum      = sat_add(x_sum, act64 * x_table[ch], WSUM_MAX);
                    y_sum      = sat_add(y_sum, act64 * y_table[ch], WSUM_MAX);
                    act_sum    = sat_add(act_sum, act64, ASUM_MAX);
                end
            end
            if (b.last)
            begin
                r.has_center = spike_seen;
                r.center_x   = center_of(x_sum, act_sum);
                r.center_y   = center_of(y_sum, act_sum);
                centers_due.insert(centers_due.size(), r);
                x_sum      = 0;
                y_sum      = 0;
                act_sum    = 0;
                spike_seen = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            armed             = 1'b0;
            spike_seen        = 1'b0;
            x_sum             = 0;
            y_sum             = 0;
            act_sum           = 0;
            centers_due.delete();
            errors            = 0;
            pending           = 0;
            frames_checked    = 0;
            frames_with_spike = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (centers_due.size() == 0)
                    report_mismatch("result beat with no frame closed", 1, 0);
                else
                begin
                    want = centers_due.pop_front();
                    if (result.has_center !== want.has_center)
                        report_mismatch("has_center", result.has_center, want.has_center);
                    if (result.center_x !== want.center_x)
                        report_mismatch("center_x", result.center_x, want.center_x);
                    if (result.center_y !== want.center_y)
                        report_mismatch("center_y", result.center_y, want.center_y);
                    frames_checked++;
                    if (want.has_center)
                        frames_with_spike++;
                end
            end
            if (item_valid && !item_stall)
                fold_item(item);
            pending = centers_due.size();
        end
    end

endmodule

[test/tb_thresholded_weighted_centroid.sv]
// Testbench top for the thresholded weighted centroid block: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_thresholded_weighted_centroid;
    import twc_pkg::*;

    localparam int ITEM_TARGET  = 950;
    localparam int DRAIN_CYCLES = 40;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int errors;
    int pending_frames;
    int frames_checked;
    int frames_with_spike;

    int idle_pct          = 0;
    int stall_pct         = 0;
    int beats_sent        = 0;
    int setups_sent       = 0;
    int samples_sent      = 0;
    int saturating_frames = 0;

    thresholded_weighted_centroid DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    twc_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item              (item),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result),
        .errors            (errors),
        .pending           (pending_frames),
        .frames_checked    (frames_checked),
        .frames_with_spike (frames_with_spike)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    function automatic item_t setup_beat(input logic [5:0] ch, input logic [15:0] thr,
                                         input logic [15:0] mn, input logic [7:0] x,
                                         input logic [7:0] y, input logic last);
        item_t b;
        b.req_type        = REQ_SETUP;
        b.channel         = ch;
        b.sample_value    = 16'($urandom);
        b.threshold_value = thr;
        b.minimum_value   = mn;
        b.x_position      = x;
        b.y_position      = y;
        b.last            = last;
        return b;
    endfunction

    function automatic item_t sample_beat(input logic [5:0] ch, input logic [15:0] v,
                                          input logic last);
        item_t b;
        b.req_type        = REQ_SAMPLE;
        b.channel         = ch;
        b.sample_value    = v;
        b.threshold_value = 16'($urandom);
        b.minimum_value   = 16'($urandom);
        b.x_position      = 8'($urandom);
        b.y_position      = 8'($urandom);
        b.last            = last;
        return b;
    endfunction

    function automatic item_t noise_beat(input logic may_close);
        if ($urandom_range(1))
            return setup_beat(6'($urandom_range(63)), 16'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom), ($urandom_range(1) != 0));
        return sample_beat(6'($urandom_range(63, CHANNELS)), 16'($urandom),
                           may_close && ($urandom_range(1) != 0));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input item_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= b;
        do
            @(posedge clk);
        while (item_stall);
        beats_sent++;
        if (b.req_type == REQ_SETUP)
            setups_sent++;
        else
            samples_sent++;
        @(negedge clk);
    endtask

    task automatic send_sequence();
        int         pick;
        int         len;
        int         ch0;
        logic [5:0] ch;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            len = ($urandom_range(9) < 7) ? $urandom_range(1, 12)
                                          : $urandom_range(13, CHANNELS);
            ch0 = $urandom_range(CHANNELS - 1);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(19) == 0)
                    send_beat(noise_beat(1'b0));
                send_beat(sample_beat(6'((ch0 + k) % CHANNELS), 16'($urandom),
                                      k == len - 1));
            end
        end
        else if (pick < 80)
        begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                send_beat(sample_beat(6'($urandom_range(63)), 16'($urandom), k == len - 1));
        end
        else if (pick < 84 && saturating_frames < 2)
        begin
            ch  = 6'($urandom_range(CHANNELS - 1));
            len = $urandom_range(66, 80);
            send_beat(setup_beat(ch, 16'h8000, 16'h8000, 8'hFF, 8'($urandom), 1'b0));
            for (int k = 0; k < len; k++)
                send_beat(sample_beat(ch, 16'h7FFF, k == len - 1));
            saturating_frames++;
        end
        else
            send_beat(noise_beat(1'b1));
    endtask

    task automatic run_phase(input int idle, input int stall, input int goal);
        idle_pct  = idle;
        stall_pct = stall;
        while (beats_sent < goal)
            send_sequence();
        item_valid <= 1'b0;
        wait (pending_frames == 0);
        @(negedge clk);
    endtask

    initial
    begin
        int base;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: unarmed samples, arming, threshold edges, zero activity,
        // out-of-range channels and reloads in the middle of a frame.
        send_beat(setup_beat(0, 16'd0, -16'sd100, 8'd255, 8'd0, 1'b0));
        send_beat(sample_beat(0, 16'd1000, 1'b1));
        send_beat(sample_beat(63, 16'h7FFF, 1'b1));
        send_beat(setup_beat(59, 16'h8000, 16'h7FFF, 8'd0, 8'd255, 1'b0));
        send_beat(setup_beat(1, 16'h7FFF, 16'h8000, 8'd128, 8'd64, 1'b0));
        send_beat(setup_beat(62, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                             1'b1));
        send_beat(sample_beat(0, 16'h7FFF, 1'b0));
        send_beat(sample_beat(59, 16'h8000, 1'b0));
        send_beat(sample_beat(1, 16'h7FFF, 1'b1));
        send_beat(sample_beat(1, 16'd0, 1'b1));
        send_beat(setup_beat(1, 16'd10, 16'd50, 8'd7, 8'd9, 1'b0));
        send_beat(sample_beat(1, 16'd50, 1'b0));
        send_beat(sample_beat(61, 16'h7FFF, 1'b1));
        send_beat(sample_beat(1, 16'd20, 1'b0));
        send_beat(setup_beat(0, 16'h8000, 16'd0, 8'd255, 8'd255, 1'b0));
        send_beat(sample_beat(0, 16'h8001, 1'b0));
        send_beat(sample_beat(59, 16'hFFFF, 1'b0));
        send_beat(sample_beat(0, 16'h7FFF, 1'b1));
        send_beat(sample_beat(60, 16'h0000, 1'b1));
        send_beat(sample_beat(0, 16'h7FFF, 1'b1));
        item_valid <= 1'b0;
        wait (pending_frames == 0);
        @(negedge clk);

        base = beats_sent;
        for (int ch = 0; ch < CHANNELS; ch++)
            send_beat(setup_beat(6'(ch), 16'($urandom), 16'($urandom), 8'($urandom),
                                 8'($urandom), ch == CHANNELS - 1));
        run_phase(0, 0, base + ITEM_TARGET / 4);
        run_phase(54, 0, base + ITEM_TARGET / 2);
        run_phase(0, 54, base + 3 * ITEM_TARGET / 4);
        run_phase(6, 6, base + ITEM_TARGET);

        item_valid <= 1'b0;
        wait (pending_frames == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats: %0d channel loads and %0d samples, %0d saturating frames.",
                 beats_sent, setups_sent, samples_sent, saturating_frames);
        $display("Checked %0d frame results, %0d of them with a spike.",
                 frames_checked, frames_with_spike);
        if (errors == 0)
            $display("** thresholded_weighted_centroid: PASSED **");
        else
            $display("** thresholded_weighted_centroid: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d frame results still outstanding.", pending_frames);
        $display("** thresholded_weighted_centroid: FAILED **");
        $finish;
    end

endmodule
